>>> design/cdq_pkg.sv
// Shared types and codes for the circular deque.
package cdq_pkg;

  typedef logic [1:0]         kind_t;
  typedef logic [1:0]         status_t;
  typedef logic signed [31:0] word_t;

  localparam kind_t KIND_PUSH_FRONT = 2'd0;
  localparam kind_t KIND_PUSH_REAR  = 2'd1;
  localparam kind_t KIND_POP_FRONT  = 2'd2;
  localparam kind_t KIND_POP_REAR   = 2'd3;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

endpackage

>>> design/cdq_if.sv
// Valid/ready channel interfaces for deque requests and results.
interface cdq_in_if;
  logic             valid;
  logic             ready;
  cdq_pkg::kind_t   kind;
  cdq_pkg::word_t   push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface cdq_out_if;
  logic             valid;
  logic             ready;
  cdq_pkg::status_t status;
  cdq_pkg::word_t   pop_value;
  logic             is_full;
  logic             is_empty;

  modport source (output valid, output status, output pop_value, output is_full,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input pop_value, input is_full,
                  input is_empty, output ready);
endinterface

>>> design/circular_deque_top.sv
// Circular deque: DEPTH-word store in a synchronous RAM with head/tail pointers.
//
// Each transfer on the request channel carries one operation (push front, push
// rear, pop front, pop rear) and yields exactly one result transfer with status,
// popped word and the full/empty flags after the operation. A push, and any
// refused operation, completes at once: the result is loaded into the output
// register at the edge the request is accepted. A successful pop goes through
// the read state first, since the slot RAM read data is registered; the request
// channel is not ready during the read state. A new request is taken while a
// result waits in the output register as long as that result is drained in the
// same cycle. No clearing pass is needed after reset.
module circular_deque_top #(
  parameter int DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  cdq_in_if.sink        in_ch,
  cdq_out_if.source     out_ch
);
  import cdq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  // Slot RAM
  word_t         mem [DEPTH];
  word_t         rd_data_r;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;

  logic          state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic          empty_r, empty_nxt;

  logic          out_valid_r, out_valid_nxt;
  status_t       status_r, status_nxt;
  word_t         pop_r, pop_nxt;
  logic          full_out_r, full_out_nxt;
  logic          empty_out_r, empty_out_nxt;

  logic          accept;
  logic          full_now;
  logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
    return (i == LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i);
    return (i == '0) ? LAST : i - 1'b1;
  endfunction

  assign head_inc = wrap_inc(head_r);
  assign head_dec = wrap_dec(head_r);
  assign tail_inc = wrap_inc(tail_r);
  assign tail_dec = wrap_dec(tail_r);
  assign full_now = !empty_r && (tail_inc == head_r);

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    empty_nxt     = empty_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    pop_nxt       = pop_r;
    full_out_nxt  = full_out_r;
    empty_out_nxt = empty_out_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = head_r;
    mem_raddr     = head_r;

    // drop the result once transferred
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (state_r == ST_READ) begin
      // read data is back: complete the pop
      out_valid_nxt = 1'b1;
      pop_nxt       = rd_data_r;
      state_nxt     = ST_IDLE;
    end else if (accept) begin
      status_nxt = ST_DONE;
      pop_nxt    = '0;
      if (in_ch.kind == KIND_PUSH_FRONT || in_ch.kind == KIND_PUSH_REAR) begin
        if (full_now) begin
          status_nxt = ST_FULL;
        end else if (empty_r) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          empty_nxt = 1'b0;
          mem_we    = 1'b1;
          mem_waddr = '0;
        end else if (in_ch.kind == KIND_PUSH_FRONT) begin
          head_nxt  = head_dec;
          mem_we    = 1'b1;
          mem_waddr = head_dec;
        end else begin
          tail_nxt  = tail_inc;
          mem_we    = 1'b1;
          mem_waddr = tail_inc;
        end
        out_valid_nxt = 1'b1;
      end else begin
        if (empty_r) begin
          status_nxt    = ST_EMPTY;
          out_valid_nxt = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = (in_ch.kind == KIND_POP_FRONT) ? head_r : tail_r;
          state_nxt = ST_READ;
          if (head_r == tail_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b1;
          end else if (in_ch.kind == KIND_POP_FRONT) begin
            head_nxt = head_inc;
          end else begin
            tail_nxt = tail_dec;
          end
        end
      end
      full_out_nxt  = !empty_nxt && (wrap_inc(tail_nxt) == head_nxt);
      empty_out_nxt = empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_ch.push_value;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    pop_r       <= pop_nxt;
    full_out_r  <= full_out_nxt;
    empty_out_r <= empty_out_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.pop_value = pop_r;
  assign out_ch.is_full   = full_out_r;
  assign out_ch.is_empty  = empty_out_r;

`ifndef NO_ASSERTIONS
  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> state_r == ST_IDLE && out_valid_r)
    else $error("pop read did not complete in one cycle");

  a_empty_resets_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> head_r == '0 && tail_r == '0)
    else $error("empty deque with nonzero pointers");

  a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != ST_DONE |-> pop_r == '0)
    else $error("refused operation returned data");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(full_out_r && empty_out_r))
    else $error("result reports full and empty together");

  a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> !in_ch.ready)
    else $error("request taken during pop read");
`endif

endmodule
